### rtl/core/c2d3v_pkg.sv
// ----------------------------------------------------------------------------
// c2d3v_pkg
// Shared types, widths and register codes of the 3x3 valid-region convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d3v_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int KERNEL_SIZE = 3;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 11;
   localparam int PIX_W       = 8;
   localparam int COEF_W      = 8;
   localparam int ROW_REG_W   = KERNEL_SIZE * COEF_W;
   localparam int TAG_W       = 10;
   localparam int PROD_W      = PIX_W + COEF_W + 1;
   localparam int ROW_SUM_W   = PROD_W + 2;
   localparam int TOTAL_W     = ROW_SUM_W + 2;
   localparam int SUM_W       = 20;
   localparam int CSR_IDX_W   = 2;

   localparam logic [ROW_REG_W-1:0] COEF_RESET  = 24'h010101;
   localparam logic [WIDTH_W-1:0]   WIDTH_RESET = 11'd5;
   localparam logic [WIDTH_W-1:0]   WIDTH_MIN   = 11'd3;
   localparam logic [WIDTH_W-1:0]   WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_TOP    = 2'd0,
      CSR_COEF_MIDDLE = 2'd1,
      CSR_COEF_BOTTOM = 2'd2,
      CSR_IMAGE_WIDTH = 2'd3
   } csr_index_type;

   typedef logic [PIX_W-1:0]                        pixel_type;
   typedef pixel_type [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] window_type;
   typedef logic signed [PROD_W-1:0]                product_type;
   typedef logic signed [ROW_SUM_W-1:0]             row_sum_type;

   // Signed coefficient k (0 = left) of a packed kernel row.
   function automatic logic signed [COEF_W-1:0] coef_at(
      input logic [ROW_REG_W-1:0] packed_row,
      input int                   k
   );
      coef_at = $signed(packed_row[ROW_REG_W-1-COEF_W*k -: COEF_W]);
   endfunction

endpackage

`default_nettype wire

### rtl/core/conv2d_3x3_valid_core.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_valid_core
// Streaming 3x3 valid-region convolution over raster-order 8-bit pixels.
// ----------------------------------------------------------------------------
// One pixel is taken every clock unless the output stalls. A result for the
// window that a pixel completes goes through line store read, window shift, nine
// parallel multiplies, row sums and the final sum into the output register, and
// only pixels at row >= 2 and column >= 2 produce one. The pipeline moves as
// a whole: while a result waits in the output register without rsp_ready,
// req_ready is low. Two line stores of 1024 x 8 bits, each with one read and
// one write port, hold the previous two rows; entries not yet written in a
// frame hold stale data. Write csr registers only while the block is idle.
`default_nettype none

module conv2d_3x3_valid_core
   import c2d3v_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // pixel input
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PIX_W-1:0]      req_pixel,
   input  wire logic                  req_frame_start,
   // result output
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [SUM_W-1:0]    rsp_window_sum,
   output logic [TAG_W-1:0]           rsp_out_row,
   output logic [TAG_W-1:0]           rsp_out_col,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ROW_REG_W-1:0]  csr_data
);

   // configuration
   logic [ROW_REG_W-1:0] coef_ff [KERNEL_SIZE];
   logic [WIDTH_W-1:0]   width_ff;
   logic [WIDTH_W-1:0]   eff_width;

   // position counters
   logic [COL_W-1:0]     col_count_ff, col_count_in;
   logic [TAG_W-1:0]     row_count_ff, row_count_in;
   logic [COL_W-1:0]     cur_col;
   logic [TAG_W-1:0]     cur_row;
   logic                 row_end;

   // line stores
   pixel_type            above_mem [MAX_WIDTH];
   pixel_type            two_mem   [MAX_WIDTH];
   pixel_type            above_rd_ff, two_rd_ff;

   // pipeline control
   logic                 advance;
   logic                 accept;
   logic                 s1_adv;

   // stage 1: line store read
   logic                 s1_valid_ff;
   pixel_type            s1_pixel_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic                 s1_emit_ff;
   logic [TAG_W-1:0]     s1_row_tag_ff, s1_col_tag_ff;
   logic                 s1_byp_ff, s1_byp_in;
   pixel_type            s1_byp_above_ff, s1_byp_two_ff;
   pixel_type            s1_above, s1_two;

   // stage 2: window
   logic                 s2_valid_ff;
   window_type           window_ff, window_in;
   logic [TAG_W-1:0]     s2_row_tag_ff, s2_col_tag_ff;

   // stage 3: products
   logic                 s3_valid_ff;
   product_type          prod_ff [KERNEL_SIZE][KERNEL_SIZE];
   product_type          prod_in [KERNEL_SIZE][KERNEL_SIZE];
   logic [TAG_W-1:0]     s3_row_tag_ff, s3_col_tag_ff;

   // stage 4: row sums
   logic                 s4_valid_ff;
   row_sum_type          row_sum_ff [KERNEL_SIZE];
   row_sum_type          row_sum_in [KERNEL_SIZE];
   logic [TAG_W-1:0]     s4_row_tag_ff, s4_col_tag_ff;

   // output register
   logic                 rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic signed [TOTAL_W-1:0] total_in;
   logic [TAG_W-1:0]     rsp_row_ff, rsp_col_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign s1_adv    = advance && s1_valid_ff;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            coef_ff[r] <= COEF_RESET;
         end
         width_ff <= WIDTH_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_TOP:    coef_ff[0] <= csr_data;
            CSR_COEF_MIDDLE: coef_ff[1] <= csr_data;
            CSR_COEF_BOTTOM: coef_ff[2] <= csr_data;
            CSR_IMAGE_WIDTH: width_ff   <= csr_data[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         eff_width = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         eff_width = WIDTH_MAX;
      end else begin
         eff_width = width_ff;
      end
   end

   // ---------------------------------------------------------------------
   // position counters
   // ---------------------------------------------------------------------
   always_comb begin
      cur_col = req_frame_start ? '0 : col_count_ff;
      cur_row = req_frame_start ? '0 : row_count_ff;
      row_end = ({1'b0, cur_col} + 1'b1) >= eff_width;
      if (row_end) begin
         col_count_in = '0;
         row_count_in = cur_row + 1'b1;
      end else begin
         col_count_in = cur_col + 1'b1;
         row_count_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // line stores: read on accept, write back as stage 1 advances, which a stall can hold off until later
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         above_rd_ff <= above_mem[cur_col];
      end
      if (s1_adv) begin
         above_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         two_rd_ff <= two_mem[cur_col];
      end
      if (s1_adv) begin
         two_mem[s1_col_ff] <= s1_above;
      end
   end

   // forward the pending write when the next pixel reads the same column
   assign s1_byp_in = s1_adv && (s1_col_ff == cur_col);
   assign s1_above  = s1_byp_ff ? s1_byp_above_ff : above_rd_ff;
   assign s1_two    = s1_byp_ff ? s1_byp_two_ff   : two_rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff     <= req_pixel;
         s1_col_ff       <= cur_col;
         s1_emit_ff      <= (cur_row >= TAG_W'(KERNEL_SIZE - 1)) &&
                            (cur_col >= COL_W'(KERNEL_SIZE - 1));
         s1_row_tag_ff   <= cur_row - TAG_W'(KERNEL_SIZE - 1);
         s1_col_tag_ff   <= TAG_W'(cur_col - COL_W'(KERNEL_SIZE - 1));
         s1_byp_ff       <= s1_byp_in;
         s1_byp_above_ff <= s1_pixel_ff;
         s1_byp_two_ff   <= s1_above;
      end
   end

   // ---------------------------------------------------------------------
   // window shift
   // ---------------------------------------------------------------------
   always_comb begin
      window_in = window_ff;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
            window_in[r][k] = window_ff[r][k+1];
         end
      end
      window_in[0][KERNEL_SIZE-1] = s1_two;
      window_in[1][KERNEL_SIZE-1] = s1_above;
      window_in[2][KERNEL_SIZE-1] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_adv) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_row_tag_ff <= s1_row_tag_ff;
         s2_col_tag_ff <= s1_col_tag_ff;
      end
   end

   // ---------------------------------------------------------------------
   // products, row sums, total
   // ---------------------------------------------------------------------
   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int k = 0; k < KERNEL_SIZE; k++) begin
            prod_in[r][k] = $signed({1'b0, window_ff[r][k]}) *
                            coef_at(coef_ff[r], k);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         row_sum_in[r] = ROW_SUM_W'(prod_ff[r][0]) + ROW_SUM_W'(prod_ff[r][1]) +
                         ROW_SUM_W'(prod_ff[r][2]);
      end
      total_in = TOTAL_W'(row_sum_ff[0]) + TOTAL_W'(row_sum_ff[1]) +
                 TOTAL_W'(row_sum_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff       <= prod_in;
         s3_row_tag_ff <= s2_row_tag_ff;
         s3_col_tag_ff <= s2_col_tag_ff;
         row_sum_ff    <= row_sum_in;
         s4_row_tag_ff <= s3_row_tag_ff;
         s4_col_tag_ff <= s3_col_tag_ff;
         rsp_sum_ff    <= total_in[SUM_W-1:0];
         rsp_row_ff    <= s4_row_tag_ff;
         rsp_col_ff    <= s4_col_tag_ff;
      end
   end

   // ---------------------------------------------------------------------
   // valid chain
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_sum = rsp_sum_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;

`ifndef ASSERT_OFF
   a_frame_start_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_start |=> col_count_ff == COL_W'(1) && row_count_ff == '0)
      else $error("frame start did not restart the position counters");

   a_emit_reaches_window: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_emit_ff |=> s2_valid_ff)
      else $error("emitting pixel lost between line read and window");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_valid_ff))
      else $error("result appeared without a pipeline item");

   a_col_tag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_col_ff <= TAG_W'(MAX_WIDTH - KERNEL_SIZE))
      else $error("window column out of range");
`endif

endmodule

`default_nettype wire

### bench/conv2d_3x3_valid_core_tb.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_valid_core_tb
// Self-checking bench for the streaming 3x3 valid-region convolution core.
// Pixel frames go in over the req channel with random gaps. A local model of
// the line stores, window and position counters predicts every rsp transfer,
// which is then compared field by field. The csr port reprograms the kernel
// rows and image width only while the core is idle, between frames or mid-row.
// ----------------------------------------------------------------------------

module conv2d_3x3_valid_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import c2d3v_pkg::*;

   localparam int CLK_PERIOD    = 4;
   localparam int MAX_IDLE      = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 20;
   localparam int RANDOM_PIXELS = 380;
   localparam int WATCHDOG_NS   = 5_000_000;

   typedef struct packed {
      logic signed [SUM_W-1:0] window_sum;
      logic [TAG_W-1:0]        top_row;
      logic [TAG_W-1:0]        left_col;
   } window_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   pixel_type               req_pixel;
   logic                    req_frame_start;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [SUM_W-1:0] rsp_window_sum;
   logic [TAG_W-1:0]        rsp_out_row;
   logic [TAG_W-1:0]        rsp_out_col;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [ROW_REG_W-1:0]    csr_data;

   // model state
   pixel_type            rows_above [MAX_WIDTH]                 = '{default: '0};
   pixel_type            rows_two_above [MAX_WIDTH]             = '{default: '0};
   pixel_type            win_px [KERNEL_SIZE][KERNEL_SIZE]      = '{default: '0};
   logic [TAG_W-1:0]     cur_col;
   logic [TAG_W-1:0]     cur_row;
   logic [ROW_REG_W-1:0] kernel_rows [KERNEL_SIZE];
   logic [WIDTH_W-1:0]   width_reg;

   window_result_type windows_pending [$];

   int unsigned idle_max = MAX_IDLE;
   int unsigned rsp_hold = 0;
   int unsigned pixels_sent = 0;
   int unsigned windows_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned errors = 0;

   conv2d_3x3_valid_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_sum  (rsp_window_sum),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // model
   // ------------------------------------------------------------------
   function automatic int unsigned row_length();
      if (width_reg < WIDTH_MIN)
         return WIDTH_MIN;
      if (width_reg > WIDTH_MAX)
         return WIDTH_MAX;
      return width_reg;
   endfunction

   // Advance the model by one pixel and queue the window it completes, if any.
   function automatic void convolve_pixel(input pixel_type px, input logic fs);
      int unsigned         eff_width;
      int unsigned         col;
      int unsigned         r;
      int unsigned         k;
      int                  acc;
      int                  coef;
      logic [COEF_W-1:0]   tap;
      window_result_type   res;
      eff_width = row_length();
      if (fs) begin
         cur_col = '0;
         cur_row = '0;
      end
      col = cur_col;
      for (r = 0; r < KERNEL_SIZE; r++) begin
         win_px[r][0] = win_px[r][1];
         win_px[r][1] = win_px[r][2];
      end
      win_px[0][2] = rows_two_above[col];
      win_px[1][2] = rows_above[col];
      win_px[2][2] = px;
      rows_two_above[col] = rows_above[col];
      rows_above[col] = px;
      if (cur_row >= 2 && col >= 2) begin
         acc = 0;
         for (r = 0; r < KERNEL_SIZE; r++) begin
            for (k = 0; k < KERNEL_SIZE; k++) begin
               // left tap sits in the top byte
               tap  = kernel_rows[r][(KERNEL_SIZE - 1 - k) * COEF_W +: COEF_W];
               coef = tap[COEF_W-1] ? int'(tap) - 256 : int'(tap);
               acc += int'(win_px[r][k]) * coef;
            end
         end
         res.window_sum = acc[SUM_W-1:0];
         res.top_row    = cur_row - 2'd2;
         res.left_col   = TAG_W'(col - 2);
         windows_pending.push_back(res);
      end
      if (col + 1 >= eff_width) begin
         cur_col = '0;
         cur_row = cur_row + 1'b1;
      end else begin
         cur_col = TAG_W'(col + 1);
      end
   endfunction

   function automatic void compare_field(input string what, input int want, input int got);
      if (want != got) begin
         if (errors < MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endfunction

   function automatic logic [ROW_REG_W-1:0] pick_kernel_row();
      case ($urandom_range(5))
         0: pick_kernel_row = 24'h7F7F7F;
         1: pick_kernel_row = 24'h808080;
         2: pick_kernel_row = {8'h80, 8'h00, 8'h7F};
         default: pick_kernel_row = ROW_REG_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned gap;
      gap = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            gap = $urandom_range(idle_max);
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else if (gap > 0) begin
            rsp_ready <= 1'b0;
            gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (windows_pending.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("%0t ns: unexpected window, sum %0d row %0d col %0d",
                        $time, rsp_window_sum, rsp_out_row, rsp_out_col);
            errors++;
         end else begin
            want = windows_pending.pop_front();
            compare_field("window_sum", want.window_sum, rsp_window_sum);
            compare_field("out_row", want.top_row, rsp_out_row);
            compare_field("out_col", want.left_col, rsp_out_col);
         end
         windows_checked++;
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------
   task automatic send_pixel(input pixel_type px, input logic fs);
      int unsigned gap;
      gap = $urandom_range(idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= px;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      convolve_pixel(px, fs);
      pixels_sent++;
   endtask

   task automatic send_frame(input int unsigned n_px, input int unsigned lo,
                             input int unsigned hi);
      int unsigned i;
      for (i = 0; i < n_px; i++)
         send_pixel(PIX_W'($urandom_range(hi, lo)), i == 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [ROW_REG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COEF_TOP:    kernel_rows[0] = data;
         CSR_COEF_MIDDLE: kernel_rows[1] = data;
         CSR_COEF_BOTTOM: kernel_rows[2] = data;
         CSR_IMAGE_WIDTH: width_reg = data[WIDTH_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_kernel(input logic [ROW_REG_W-1:0] top, input logic [ROW_REG_W-1:0] mid,
                             input logic [ROW_REG_W-1:0] bot);
      write_csr(CSR_COEF_TOP, top);
      write_csr(CSR_COEF_MIDDLE, mid);
      write_csr(CSR_COEF_BOTTOM, bot);
   endtask

   // Drop valid, wait for every queued window, then let the pipeline empty.
   task automatic drain_results();
      int unsigned waited;
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (windows_pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (windows_pending.size() != 0) begin
         $display("%0t ns: %0d expected windows never arrived", $time, windows_pending.size());
         errors++;
         windows_pending.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_reset_defaults();
      int unsigned i;
      // width 5 and all-ones kernel out of reset; no start flag needed
      for (i = 0; i < 13; i++)
         send_pixel(i[0] ? 8'hFF : 8'h00, 1'b0);
      drain_results();
   endtask

   task automatic test_extreme_sums();
      set_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
      write_csr(CSR_IMAGE_WIDTH, 24'd3);
      send_frame(9, 255, 255);
      drain_results();
      set_kernel(24'h808080, 24'h808080, 24'h808080);
      // below the legal range, counts as 3
      write_csr(CSR_IMAGE_WIDTH, 24'd0);
      send_frame(9, 255, 255);
      drain_results();
   endtask

   task automatic test_frame_restart();
      set_kernel(24'h01FF02, 24'hFE0403, 24'h7F80FF);
      write_csr(CSR_IMAGE_WIDTH, 24'd4);
      send_frame(10, 0, 255);
      // restart mid-row, then two starts back to back
      send_frame(12, 0, 255);
      send_pixel(8'h55, 1'b1);
      send_frame(13, 0, 255);
      drain_results();
   endtask

   task automatic test_width_shrink_mid_row();
      int unsigned i;
      write_csr(CSR_IMAGE_WIDTH, 24'd8);
      send_frame(22, 0, 255);
      drain_results();
      // column 6 is already past the new width, so the next pixel ends the row
      write_csr(CSR_IMAGE_WIDTH, 24'd4);
      for (i = 0; i < 9; i++)
         send_pixel(PIX_W'($urandom_range(255)), 1'b0);
      drain_results();
   endtask

   task automatic test_max_width();
      logic [ROW_REG_W-1:0] wdata;
      set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      wdata = ROW_REG_W'($urandom);
      wdata[WIDTH_W-1:0] = '1;
      write_csr(CSR_IMAGE_WIDTH, wdata);
      // clamped to the longest row: the first row must not end early
      send_frame(48, 0, 255);
      drain_results();
   endtask

   task automatic test_back_to_back();
      idle_max = 0;
      // below the legal range, counts as 3
      write_csr(CSR_IMAGE_WIDTH, 24'd2);
      send_frame(60, 0, 255);
      drain_results();
      idle_max = MAX_IDLE;
   endtask

   task automatic test_backpressure();
      write_csr(CSR_IMAGE_WIDTH, 24'd6);
      rsp_hold = 120;
      send_frame(60, 0, 255);
      drain_results();
   endtask

   task automatic test_random_frames();
      int unsigned          target;
      int unsigned          rows;
      int unsigned          n_px;
      int unsigned          first;
      int unsigned          s;
      int unsigned          i;
      int unsigned          w_sel;
      logic [WIDTH_W-1:0]   w_code;
      logic [ROW_REG_W-1:0] wdata;
      csr_index_type        reg_order [4];
      reg_order = '{CSR_COEF_TOP, CSR_COEF_MIDDLE, CSR_COEF_BOTTOM, CSR_IMAGE_WIDTH};
      target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < target) begin
         drain_results();
         idle_max = ($urandom_range(4) == 0) ? 0 : MAX_IDLE;
         first = $urandom_range(3);
         for (s = 0; s < 4; s++) begin
            case (reg_order[(first + s) % 4])
               CSR_IMAGE_WIDTH: begin
                  w_sel = $urandom_range(9);
                  if (w_sel == 0)
                     w_code = WIDTH_W'($urandom_range(2));
                  else if (w_sel == 1)
                     w_code = WIDTH_W'($urandom_range(40, 13));
                  else
                     w_code = WIDTH_W'($urandom_range(12, 3));
                  wdata = ROW_REG_W'($urandom);
                  wdata[WIDTH_W-1:0] = w_code;
                  write_csr(CSR_IMAGE_WIDTH, wdata);
               end
               default: begin
                  if ($urandom_range(3) != 0)
                     write_csr(reg_order[(first + s) % 4], pick_kernel_row());
               end
            endcase
         end
         rows = $urandom_range(8, 1);
         n_px = rows * row_length() + $urandom_range(row_length() - 1);
         // mostly clean frames, with a stray frame start now and then
         for (i = 0; i < n_px; i++)
            send_pixel(PIX_W'($urandom_range(255)), (i == 0) || ($urandom_range(40) == 0));
      end
      idle_max = MAX_IDLE;
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      req_valid       = 1'b0;
      req_pixel       = '0;
      req_frame_start = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_COEF_TOP;
      csr_data        = '0;
      reset           = 1'b1;
      kernel_rows     = '{COEF_RESET, COEF_RESET, COEF_RESET};
      width_reg       = WIDTH_RESET;
      cur_col         = '0;
      cur_row         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_extreme_sums();
      test_frame_restart();
      test_width_shrink_mid_row();
      test_max_width();
      test_back_to_back();
      test_backpressure();
      test_random_frames();

      $display("Sent %0d pixels, checked %0d windows, made %0d register writes.",
               pixels_sent, windows_checked, csr_writes);
      $display("Covered kernel extremes, widths 3 to 40 with clamping at both ends, ",
               "frame restarts, a mid-row width cut, back-to-back transfers and long stalls.");
      if (errors == 0) begin
         $display("** conv2d_3x3_valid_core: PASSED **");
      end else begin
         $display("** conv2d_3x3_valid_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("%0t ns: run did not finish in time", $time);
      $display("** conv2d_3x3_valid_core: FAILED **");
      $finish;
   end

endmodule
